FILE: rtl/adsr_envelope_generator_unit_macros.svh
// ----------------------------------------------------------------------------
// adsr envelope generator assertion macros
// Shared concurrent assertion forms for the envelope generator.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_GENERATOR_UNIT_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define ADSR_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adsr assertion failed");

// next-cycle implication
`define ADSR_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adsr assertion failed");

`endif

FILE: rtl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Types, codes and constants shared by the envelope generator modules.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int AMP_BITS      = 16;
  localparam int DT_BITS       = 8;
  localparam int TIME_BITS_DEF = 16;
  localparam int CMD_BITS      = 2;
  localparam int PHASE_BITS    = 3;
  localparam int CFG_IDX_BITS  = 3;

  localparam int RST_ATTACK_LEVEL  = 65535;
  localparam int RST_SUSTAIN_LEVEL = 32768;
  localparam int RST_ATTACK_TIME   = 1000;
  localparam int RST_DECAY_TIME    = 1000;
  localparam int RST_RELEASE_TIME  = 1000;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK     = 2'd0,
    CMD_GATE_ON  = 2'd1,
    CMD_GATE_OFF = 2'd2
  } cmd_code_t;

  typedef enum logic [PHASE_BITS-1:0] {
    PH_IDLE = 3'd0,
    PH_ATK  = 3'd1,
    PH_DEC  = 3'd2,
    PH_SUS  = 3'd3,
    PH_REL  = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ATTACK_LEVEL  = 3'd0,
    REG_SUSTAIN_LEVEL = 3'd1,
    REG_ATTACK_TIME   = 3'd2,
    REG_DECAY_TIME    = 3'd3,
    REG_RELEASE_TIME  = 3'd4,
    REG_SUSTAINABLE   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LOAD = 2'd1,
    S_DIV  = 2'd2,
    S_DONE = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic [CMD_BITS-1:0] command;
    logic [DT_BITS-1:0]  delta_time;
  } req_t;

  typedef struct packed {
    logic [AMP_BITS-1:0]   amplitude;
    logic [PHASE_BITS-1:0] phase;
  } res_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_status_t;

endpackage

FILE: rtl/adsr_ctrl.sv
// ----------------------------------------------------------------------------
// adsr_ctrl
// Sequencer: takes a request, runs the multiply and, when needed, the serial divide, commits.
// ----------------------------------------------------------------------------
module adsr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  output logic                   res_valid,
  input  logic                   res_stall,
  input  adsr_pkg::dp_status_t   status,
  output adsr_pkg::ctrl_cmd_t    cmd
);
  import adsr_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_free;

  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_LOAD;
      end
      S_LOAD: begin
        state_next = status.need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (status.div_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = 1'b1;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        req_stall  = 1'b0;
        cmd.accept = req_valid;
      end
      S_LOAD: cmd.load = 1'b1;
      S_DIV:  cmd.step = 1'b1;
      S_DONE: cmd.commit = out_free;
      default: req_stall = 1'b1;
    endcase
  end

endmodule

FILE: rtl/adsr_dp.sv
// ----------------------------------------------------------------------------
// adsr_dp
// Envelope state, configuration registers, step multiplier and
// restoring divider.
// ----------------------------------------------------------------------------
module adsr_dp #(
  parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF,
  parameter int CFG_BITS  = (adsr_pkg::AMP_BITS > TIME_BITS) ? adsr_pkg::AMP_BITS : TIME_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [adsr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_BITS-1:0]                 cfg_data,
  input  adsr_pkg::req_t                      req,
  input  adsr_pkg::ctrl_cmd_t                 cmd,
  output adsr_pkg::dp_status_t                status,
  output adsr_pkg::res_t                      res
);
  import adsr_pkg::*;

  localparam int P        = AMP_BITS + DT_BITS;
  localparam int W        = P + 1;
  localparam int CNT_BITS = $clog2(P);

  logic [AMP_BITS-1:0]  attack_level;
  logic [AMP_BITS-1:0]  sustain_level;
  logic [TIME_BITS-1:0] attack_time;
  logic [TIME_BITS-1:0] decay_time;
  logic [TIME_BITS-1:0] release_time;
  logic                 sustainable;

  logic [AMP_BITS-1:0]  level;
  phase_t               stage;
  logic                 hold;
  logic [CMD_BITS-1:0]  req_cmd;
  logic [DT_BITS-1:0]   req_dt;

  logic [P-1:0]         dvd;
  logic [TIME_BITS-1:0] rem;
  logic [CNT_BITS-1:0]  cnt;

  logic [AMP_BITS-1:0]  sel_span;
  logic [TIME_BITS-1:0] sel_dur;
  logic                 inst;
  logic                 divides;
  logic [P-1:0]         prod;
  logic [TIME_BITS:0]   rem_sh;
  logic                 q_bit;

  logic [W-1:0]         lvl_w;
  logic [W-1:0]         q_w;
  logic [W-1:0]         sum_w;
  logic [W-1:0]         dec_w;
  logic [AMP_BITS-1:0]  level_next;
  phase_t               stage_next;
  logic                 hold_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_level  <= AMP_BITS'(RST_ATTACK_LEVEL);
      sustain_level <= AMP_BITS'(RST_SUSTAIN_LEVEL);
      attack_time   <= TIME_BITS'(RST_ATTACK_TIME);
      decay_time    <= TIME_BITS'(RST_DECAY_TIME);
      release_time  <= TIME_BITS'(RST_RELEASE_TIME);
      sustainable   <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ATTACK_LEVEL:  attack_level  <= cfg_data[AMP_BITS-1:0];
        REG_SUSTAIN_LEVEL: sustain_level <= cfg_data[AMP_BITS-1:0];
        REG_ATTACK_TIME:   attack_time   <= cfg_data[TIME_BITS-1:0];
        REG_DECAY_TIME:    decay_time    <= cfg_data[TIME_BITS-1:0];
        REG_RELEASE_TIME:  release_time  <= cfg_data[TIME_BITS-1:0];
        REG_SUSTAINABLE:   sustainable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // span and duration of the running segment
  always_comb begin
    sel_span = '0;
    sel_dur  = '0;
    divides  = 1'b0;
    case (stage)
      PH_ATK: begin
        sel_span = attack_level;
        sel_dur  = attack_time;
        divides  = 1'b1;
      end
      PH_DEC: begin
        sel_span = (attack_level > sustain_level) ? attack_level - sustain_level : '0;
        sel_dur  = decay_time;
        divides  = 1'b1;
      end
      PH_REL: begin
        sel_span = sustain_level;
        sel_dur  = release_time;
        divides  = 1'b1;
      end
      default: divides = 1'b0;
    endcase
  end

  assign inst   = (sel_dur == '0);
  assign prod   = P'(sel_span) * P'(req_dt);
  assign rem_sh = {rem, dvd[P-1]};
  assign q_bit  = (rem_sh >= {1'b0, sel_dur});

  assign status.need_div = (req_cmd == CMD_TICK) && divides && !inst;
  assign status.div_last = (cnt == CNT_BITS'(P - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_cmd <= req.command;
      req_dt  <= req.delta_time;
    end
    if (cmd.load) begin
      dvd <= prod;
      rem <= '0;
    end else if (cmd.step) begin
      dvd <= {dvd[P-2:0], q_bit};
      rem <= q_bit ? TIME_BITS'(rem_sh - {1'b0, sel_dur}) : rem_sh[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // envelope update from the quotient
  assign lvl_w = W'(level);
  assign q_w   = {1'b0, dvd};
  assign sum_w = lvl_w + q_w;
  assign dec_w = (q_w >= lvl_w) ? '0 : lvl_w - q_w;

  always_comb begin
    level_next = level;
    stage_next = stage;
    hold_next  = hold;
    case (req_cmd)
      CMD_TICK: begin
        case (stage)
          PH_ATK: begin
            if (inst || sum_w >= W'(attack_level)) begin
              level_next = attack_level;
              stage_next = PH_DEC;
            end else begin
              level_next = sum_w[AMP_BITS-1:0];
            end
          end
          PH_DEC: begin
            if (inst || dec_w <= W'(sustain_level)) begin
              level_next = sustain_level;
              stage_next = PH_SUS;
            end else begin
              level_next = dec_w[AMP_BITS-1:0];
            end
          end
          PH_SUS: begin
            if (!hold) stage_next = PH_REL;
          end
          PH_REL: begin
            if (inst || q_w >= lvl_w) begin
              level_next = '0;
              stage_next = PH_IDLE;
            end else begin
              level_next = dec_w[AMP_BITS-1:0];
            end
          end
          default: stage_next = stage;
        endcase
      end
      CMD_GATE_ON: begin
        hold_next  = sustainable;
        stage_next = PH_ATK;
      end
      CMD_GATE_OFF: hold_next = 1'b0;
      default: hold_next = hold;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      stage <= PH_IDLE;
      hold  <= 1'b0;
    end else if (cmd.commit) begin
      level <= level_next;
      stage <= stage_next;
      hold  <= hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res.amplitude <= level_next;
      res.phase     <= stage_next;
    end
  end

endmodule

FILE: rtl/adsr_envelope_generator_unit.sv
// ----------------------------------------------------------------------------
// adsr_envelope_generator_unit
// Linear ADSR envelope generator, fixed point, one result per request.
// ----------------------------------------------------------------------------
// Each request is a command (tick, gate on, gate off) with a time delta, and
// gives one result: the amplitude (unsigned Q0.16) and phase after the step.
// A tick in attack, decay or release with a nonzero segment time latches the
// request, forms the span times delta product, takes one quotient bit per
// cycle from the restoring divider and then commits. All other requests
// latch, load and commit without the divide. A finished result sits in the
// output register, so the next request is taken while it waits.
// Configuration is written through cfg_write, cfg_index and cfg_data; the
// user must do so only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_unit #(
  parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF,
  parameter int CFG_BITS  = (adsr_pkg::AMP_BITS > TIME_BITS) ? adsr_pkg::AMP_BITS : TIME_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [adsr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]               cfg_data,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  adsr_pkg::req_t                    req,
  output logic                              res_valid,
  input  logic                              res_stall,
  output adsr_pkg::res_t                    res
);
  import adsr_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  adsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (dp_status),
    .cmd       (ctrl_cmd)
  );

  adsr_dp #(
    .TIME_BITS (TIME_BITS),
    .CFG_BITS  (CFG_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (ctrl_cmd),
    .status    (dp_status),
    .res       (res)
  );

`include "adsr_envelope_generator_unit_macros.svh"

  `ADSR_ASSERT_NXT(a_busy_after_req, clk, rst, req_valid && !req_stall, req_stall)
  `ADSR_ASSERT_IMP(a_commit_slot_free, clk, rst, ctrl_cmd.commit, !res_valid || !res_stall)
  `ADSR_ASSERT_IMP(a_idle_is_silent, clk, rst, res_valid && (res.phase == PH_IDLE),
                   res.amplitude == '0)
  `ADSR_ASSERT_IMP(a_no_req_in_divide, clk, rst, ctrl_cmd.step, req_stall)

endmodule

FILE: sim/adsr_envelope_monitor.sv
// ----------------------------------------------------------------------------
// adsr_envelope_monitor
// Watches the config port and both request/result channels of the envelope
// generator, tracks the envelope it should produce and compares every result
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module adsr_envelope_monitor
  import adsr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [AMP_BITS-1:0]     cfg_data,
  input  logic                    req_valid,
  input  logic                    req_stall,
  input  req_t                    req,
  input  logic                    res_valid,
  input  logic                    res_stall,
  input  res_t                    res,
  output int                      failures,
  output int                      outstanding
);

  logic [AMP_BITS-1:0] peak_level;
  logic [AMP_BITS-1:0] hold_level;
  logic [AMP_BITS-1:0] attack_span;
  logic [AMP_BITS-1:0] decay_span;
  logic [AMP_BITS-1:0] release_span;
  logic                hold_enable;

  logic [AMP_BITS-1:0] env_level;
  phase_t              env_phase;
  logic                env_hold;

  res_t pending_levels[$];
  int   mismatch_count = 0;

  assign failures = mismatch_count;

  function automatic logic [31:0] ramp_step(input logic [AMP_BITS-1:0] span,
                                            input logic [DT_BITS-1:0] dt,
                                            input logic [AMP_BITS-1:0] dur);
    if (dur == '0) return 32'd0;
    return (32'(span) * 32'(dt)) / 32'(dur);
  endfunction

  task automatic step_envelope(input logic [DT_BITS-1:0] dt);
    logic [31:0] delta;
    logic [31:0] next_level;
    logic [AMP_BITS-1:0] span;
    case (env_phase)
      PH_ATK: begin
        delta = ramp_step(peak_level, dt, attack_span);
        if (attack_span == '0 || 32'(env_level) + delta >= 32'(peak_level)) begin
          env_level = peak_level;
          env_phase = PH_DEC;
        end else begin
          env_level = AMP_BITS'(32'(env_level) + delta);
        end
      end
      PH_DEC: begin
        span = (peak_level > hold_level) ? peak_level - hold_level : '0;
        delta = ramp_step(span, dt, decay_span);
        next_level = (delta >= 32'(env_level)) ? 32'd0 : 32'(env_level) - delta;
        if (decay_span == '0 || next_level <= 32'(hold_level)) begin
          env_level = hold_level;
          env_phase = PH_SUS;
        end else begin
          env_level = AMP_BITS'(next_level);
        end
      end
      PH_SUS: begin
        if (!env_hold) env_phase = PH_REL;
      end
      PH_REL: begin
        delta = ramp_step(hold_level, dt, release_span);
        if (release_span == '0 || delta >= 32'(env_level)) begin
          env_level = '0;
          env_phase = PH_IDLE;
        end else begin
          env_level = AMP_BITS'(32'(env_level) - delta);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      peak_level   = AMP_BITS'(RST_ATTACK_LEVEL);
      hold_level   = AMP_BITS'(RST_SUSTAIN_LEVEL);
      attack_span  = AMP_BITS'(RST_ATTACK_TIME);
      decay_span   = AMP_BITS'(RST_DECAY_TIME);
      release_span = AMP_BITS'(RST_RELEASE_TIME);
      hold_enable  = 1'b1;
      env_level    = '0;
      env_phase    = PH_IDLE;
      env_hold     = 1'b0;
      pending_levels.delete();
      outstanding <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (pending_levels.size() == 0) begin
          $error("result with no request outstanding: amplitude %0d phase %0d",
                 res.amplitude, res.phase);
          mismatch_count++;
        end else begin
          want = pending_levels.pop_front();
          if (res.amplitude !== want.amplitude) begin
            $error("amplitude: expected %0d, actual %0d", want.amplitude, res.amplitude);
            mismatch_count++;
          end
          if (res.phase !== want.phase) begin
            $error("phase: expected %0d, actual %0d", want.phase, res.phase);
            mismatch_count++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_ATTACK_LEVEL:  peak_level   = cfg_data;
          REG_SUSTAIN_LEVEL: hold_level   = cfg_data;
          REG_ATTACK_TIME:   attack_span  = cfg_data;
          REG_DECAY_TIME:    decay_span   = cfg_data;
          REG_RELEASE_TIME:  release_span = cfg_data;
          REG_SUSTAINABLE:   hold_enable  = cfg_data[0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        case (req.command)
          CMD_TICK: step_envelope(req.delta_time);
          CMD_GATE_ON: begin
            env_hold  = hold_enable;
            env_phase = PH_ATK;
          end
          CMD_GATE_OFF: env_hold = 1'b0;
          default: ;
        endcase
        want.amplitude = env_level;
        want.phase     = env_phase;
        pending_levels.push_back(want);
      end
      outstanding <= pending_levels.size();
    end
  end

endmodule

FILE: sim/adsr_envelope_generator_unit_test.sv
// ----------------------------------------------------------------------------
// adsr_envelope_generator_unit_test
// Drives the envelope generator with directed corner sequences and then with
// randomized note sequences (gate on, ticks, gate off, ticks, plus noise)
// under a range of register settings, random gaps on both channels and one
// long result hold-off; the monitor checks every result.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_unit_test;
  import adsr_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_write = 1'b0;
  cfg_reg_t            cfg_index = REG_ATTACK_LEVEL;
  logic [AMP_BITS-1:0] cfg_data  = '0;
  logic                req_valid = 1'b0;
  logic                req_stall;
  req_t                req       = '0;
  logic                res_valid;
  logic                res_stall = 1'b1;
  res_t                res;

  int failures;
  int outstanding;
  int sent_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  adsr_envelope_generator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  adsr_envelope_monitor envelope_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // quiet windows with no idling, otherwise random gaps
  function automatic int pick_gap(input int n);
    if ((n / 100) % 4 == 2) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [AMP_BITS-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return AMP_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [AMP_BITS-1:0] pick_duration();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return AMP_BITS'(1);
      default: return AMP_BITS'($urandom_range(2, 1500));
    endcase
  endfunction

  function automatic logic [DT_BITS-1:0] pick_dt();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return DT_BITS'($urandom);
    endcase
  endfunction

  task automatic send(input logic [CMD_BITS-1:0] cmd, input logic [DT_BITS-1:0] dt);
    int gap;
    gap = pick_gap(sent_count);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{command: cmd, delta_time: dt};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_noisy(input logic [CMD_BITS-1:0] cmd, input logic [DT_BITS-1:0] dt);
    if ($urandom_range(0, 9) == 0)
      send(CMD_BITS'($urandom_range(0, 3)), DT_BITS'($urandom));
    else
      send(cmd, dt);
  endtask

  task automatic play_note();
    int n;
    send_noisy(CMD_GATE_ON, DT_BITS'($urandom));
    n = $urandom_range(0, 40);
    repeat (n) send_noisy(CMD_TICK, pick_dt());
    send_noisy(CMD_GATE_OFF, DT_BITS'($urandom));
    n = $urandom_range(0, 30);
    repeat (n) send_noisy(CMD_TICK, pick_dt());
  endtask

  // registers change only with nothing in flight
  task automatic apply_setting(input logic [AMP_BITS-1:0] peak, input logic [AMP_BITS-1:0] sus,
                               input logic [AMP_BITS-1:0] atk, input logic [AMP_BITS-1:0] dec,
                               input logic [AMP_BITS-1:0] rel, input logic hold_ok);
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_ATTACK_LEVEL;
    cfg_data  <= peak;
    @(posedge clk);
    cfg_index <= REG_SUSTAIN_LEVEL;
    cfg_data  <= sus;
    @(posedge clk);
    cfg_index <= REG_ATTACK_TIME;
    cfg_data  <= atk;
    @(posedge clk);
    cfg_index <= REG_DECAY_TIME;
    cfg_data  <= dec;
    @(posedge clk);
    cfg_index <= REG_RELEASE_TIME;
    cfg_data  <= rel;
    @(posedge clk);
    cfg_index <= REG_SUSTAINABLE;
    cfg_data  <= AMP_BITS'(hold_ok);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    int phase_idx;
    int target;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset setting: an idle tick, spare command, idle gate off, a full held note
    send(CMD_TICK, 8'd0);
    send(CMD_SPARE, 8'hAA);
    send(CMD_GATE_OFF, 8'h55);
    send(CMD_GATE_ON, 8'd0);
    repeat (4) send(CMD_TICK, 8'hFF);
    send(CMD_TICK, 8'd0);
    repeat (4) send(CMD_TICK, 8'hFF);
    send(CMD_TICK, 8'hFF);
    send(CMD_GATE_OFF, 8'd0);
    send(CMD_TICK, 8'd1);
    repeat (4) send(CMD_TICK, 8'hFF);

    // sustain above peak, zero release, no hold
    apply_setting(16'h1000, 16'hFFFF, 16'd1, 16'd500, 16'd0, 1'b0);
    send(CMD_GATE_ON, 8'd0);
    send(CMD_TICK, 8'hFF);
    send(CMD_TICK, 8'd200);
    send(CMD_TICK, 8'd9);
    send(CMD_GATE_ON, 8'hFF);
    send(CMD_TICK, 8'd0);
    send(CMD_TICK, 8'd3);
    send(CMD_TICK, 8'd5);
    send(CMD_TICK, 8'd1);

    for (phase_idx = 0; phase_idx < 10; phase_idx++) begin
      case (phase_idx)
        0:       apply_setting('1, '1, '1, '1, '1, 1'b1);
        1:       apply_setting('1, '0, 16'd1, 16'd1, 16'd1, 1'b0);
        default: apply_setting(pick_level(), pick_level(), pick_duration(), pick_duration(),
                               pick_duration(), 1'($urandom_range(0, 1)));
      endcase
      target = sent_count + 128;
      while (sent_count < target) play_note();
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin : drain
    int taken;
    int wait_n;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // one long hold-off so the block backs up into the request side
      wait_n = (taken == 250) ? 400 : pick_gap(taken);
      if (wait_n != 0) begin
        res_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : watchdog
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
